@@ rtl/core/ufr_pkg.sv @@
// shared types, codes and constants of the uart frame receiver
`default_nettype none
package ufr_pkg;

  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam int unsigned HEADER_BYTES = 4;
  localparam logic [15:0] TIMEOUT_RESET = 16'd50;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd512;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD = 1'd1;

  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_GOOD = 3'd1,
    KIND_BAD_SUM = 3'd2,
    KIND_TOO_LONG = 3'd3,
    KIND_TIMEOUT = 3'd4
  } kind_t;

  typedef struct packed {
    logic operation;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    kind_t kind;
    logic [7:0] command;
    logic [7:0] data_byte;
    logic [15:0] position;
  } out_item_t;

endpackage
`default_nettype wire

@@ rtl/core/ufr_front.sv @@
// front part: frame state, configuration and classification of each request
`default_nettype none
module ufr_front
  import ufr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic accept,
  input  wire in_item_t item,
  output logic push,
  output out_item_t result
);

  logic [15:0] timeout_ticks;
  logic [15:0] max_payload;
  logic [16:0] byte_count, byte_count_next;
  logic [15:0] declared_length, declared_length_next;
  logic [7:0] frame_command, frame_command_next;
  logic [7:0] running_sum, running_sum_next;
  logic [15:0] idle_ticks, idle_ticks_next;
  logic emit;
  logic [16:0] pos;
  logic [7:0] b;

  assign b = item.byte_value;
  assign pos = byte_count - 17'(HEADER_BYTES);

  always_comb begin
    byte_count_next = byte_count;
    declared_length_next = declared_length;
    frame_command_next = frame_command;
    running_sum_next = running_sum;
    idle_ticks_next = idle_ticks;
    emit = 1'b0;
    result.kind = KIND_PAYLOAD;
    result.command = frame_command;
    result.data_byte = 8'd0;
    result.position = 16'd0;
    if (item.operation == OP_TICK) begin
      if (idle_ticks != 16'hFFFF) idle_ticks_next = idle_ticks + 16'd1;
    end else if (byte_count != 17'd0 && idle_ticks > timeout_ticks) begin
      emit = 1'b1;
      result.kind = KIND_TIMEOUT;
      result.command = 8'd0;
      result.position = byte_count[16] ? 16'hFFFF : byte_count[15:0];
      idle_ticks_next = 16'd0;
      declared_length_next = 16'd0;
      frame_command_next = 8'd0;
      if (b == START_BYTE) begin
        byte_count_next = 17'd1;
        running_sum_next = b;
      end else begin
        byte_count_next = 17'd0;
        running_sum_next = 8'd0;
      end
    end else begin
      idle_ticks_next = 16'd0;
      priority if (byte_count == 17'd0) begin
        if (b == START_BYTE) begin
          byte_count_next = 17'd1;
          running_sum_next = b;
        end
      end else if (byte_count == 17'd1) begin
        frame_command_next = b;
        running_sum_next = running_sum + b;
        byte_count_next = 17'd2;
      end else if (byte_count == 17'd2) begin
        declared_length_next = {8'd0, b};
        running_sum_next = running_sum + b;
        byte_count_next = 17'd3;
      end else if (byte_count == 17'd3) begin
        declared_length_next = {b, declared_length[7:0]};
        running_sum_next = running_sum + b;
        byte_count_next = 17'(HEADER_BYTES);
        if ({b, declared_length[7:0]} > max_payload) begin
          emit = 1'b1;
          result.kind = KIND_TOO_LONG;
          result.position = {b, declared_length[7:0]};
          byte_count_next = 17'd0;
          declared_length_next = 16'd0;
          frame_command_next = 8'd0;
          running_sum_next = 8'd0;
        end
      end else if (pos < {1'b0, declared_length}) begin
        emit = 1'b1;
        result.kind = KIND_PAYLOAD;
        result.data_byte = b;
        result.position = pos[15:0];
        running_sum_next = running_sum + b;
        byte_count_next = byte_count + 17'd1;
      end else begin
        emit = 1'b1;
        result.kind = (b == running_sum) ? KIND_GOOD : KIND_BAD_SUM;
        result.data_byte = b;
        result.position = declared_length;
        byte_count_next = 17'd0;
        declared_length_next = 16'd0;
        frame_command_next = 8'd0;
        running_sum_next = 8'd0;
      end
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      max_payload <= MAX_PAYLOAD_RESET;
      byte_count <= 17'd0;
      declared_length <= 16'd0;
      frame_command <= 8'd0;
      running_sum <= 8'd0;
      idle_ticks <= 16'd0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
          REG_MAX_PAYLOAD: max_payload <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        byte_count <= byte_count_next;
        declared_length <= declared_length_next;
        frame_command <= frame_command_next;
        running_sum <= running_sum_next;
        idle_ticks <= idle_ticks_next;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ufr_back.sv @@
// back part: result queue that presents results on the output channel
`default_nettype none
module ufr_back
  import ufr_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire out_item_t push_item,
  output logic full,
  output logic out_valid,
  input  wire logic out_stall,
  output out_item_t out_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  out_item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic pop;

  assign full = (count == CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data = mem[rd_ptr];
  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/uart_frame_receiver_unit.sv @@
// top level of the uart frame receiver: front classifier and result queue
`default_nettype none
// Takes one request per clock: each received byte or millisecond tick updates the
// frame state in the front part, and any result it causes goes
// into a small result queue (QUEUE_DEPTH entries, two by default) that drives the
// output channel. Input is stalled only while that queue is full, so with the
// output taken every cycle the block sustains one request per cycle and a result
// appears in the cycle after the request that caused it. Configuration writes are
// taken in any cycle outside reset and hold no reset pass.
module uart_frame_receiver_unit
  import ufr_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire in_item_t in_data,
  output logic out_valid,
  input  wire logic out_stall,
  output out_item_t out_data
);

  logic accept;
  logic push;
  logic full;
  out_item_t result;

  assign in_stall = full;
  assign accept = in_valid && !full;

  ufr_front u_front (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .accept(accept),
    .item(in_data),
    .push(push),
    .result(result)
  );

  ufr_back #(.DEPTH(DEPTH)) u_back (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_item(result),
    .full(full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

endmodule
`default_nettype wire

@@ rtl/core/ufr_checker.sv @@
// port checker of the uart frame receiver and its bind
`default_nettype none
module ufr_checker
  import ufr_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire in_item_t in_data,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown straight after reset");

  a_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_tick_silent: assert property (@(posedge clk) disable iff (rst)
    !out_valid && in_valid && !in_stall && in_data.operation == OP_TICK |=> !out_valid)
    else $error("tick request produced a result");

  a_timeout_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_TIMEOUT |->
      out_data.command == 8'd0 && out_data.data_byte == 8'd0)
    else $error("timeout abort carries command or data");

  a_too_long_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_TOO_LONG |-> out_data.data_byte == 8'd0)
    else $error("length abort carries data");

endmodule

bind uart_frame_receiver_unit ufr_checker u_ufr_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .in_data(in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data(out_data)
);
`default_nettype wire
